// ----- rtl/crc8pd_pkg.sv -----
// crc8pd_pkg: shared types and constants for the crc-8 packet deframer
// no dependencies; imported by crc8pd_crc_byte and crc8_packet_deframer
package crc8pd_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned SEQ_W             = 4;
  localparam int unsigned CAM_W             = 2;
  localparam int unsigned NUM_CAMS          = 4;
  localparam int unsigned PAYLOAD_BYTES_DEF = 8;
  localparam int unsigned SEQ_MODULUS_DEF   = 16;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [CAM_W-1:0]  cam_t;

  typedef enum logic {
    CFG_PREAMBLE = 1'b0,
    CFG_POLY     = 1'b1
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_HUNT  = 5'b00001,
    ST_ADDR  = 5'b00010,
    ST_DATA  = 5'b00100,
    ST_CRC   = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  // fields of the latched address byte
  typedef struct packed {
    cam_t               cam;
    logic [1:0]         port;
    seq_t               seq;
  } addr_t;

endpackage

// ----- rtl/crc8pd_crc_byte.sv -----
// crc8pd_crc_byte: one byte of crc-8, msb first, no reflection
// depends on crc8pd_pkg
module crc8pd_crc_byte
  import crc8pd_pkg::*;
(
  input  byte_t crc_in,
  input  byte_t data_in,
  input  byte_t poly,
  output byte_t crc_out
);

  always_comb begin
    byte_t c;
    c = crc_in ^ data_in;
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ----- rtl/crc8_packet_deframer.sv -----
// crc8_packet_deframer: preamble hunt, packet capture, crc-8 check, sequence tracking
// first payload result after the crc byte: drain state, payload memory read, output register
// throughput: one byte per cycle in, input stalled while draining; PAYLOAD_BYTES results
//   drained one at a time (payload memory read, then output register, next read once it frees)
// reset: synchronous active-low rst_n clears control state and sequence valid bits
// depends on crc8pd_pkg and crc8pd_crc_byte
module crc8_packet_deframer
  import crc8pd_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int unsigned SEQ_MODULUS   = SEQ_MODULUS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_camera_id,
  output logic [1:0]  out_port_id,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_byte,
  output logic        out_crc_error,
  output logic        out_packet_lost
);

  localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

  state_t            state_r, state_nxt;
  byte_t             preamble_r, poly_r;
  addr_t             addr_r;
  byte_t             crc_acc_r;
  logic [IDX_W-1:0]  wr_idx_r, rd_idx_r;
  logic              rd_pend_r;
  logic              crc_err_r, lost_r;
  logic              out_valid_r, out_last_r;
  byte_t             out_data_r;
  cam_t              out_cam_r;
  logic [1:0]        out_port_r;
  logic              out_crc_err_r, out_lost_r;
  byte_t             crc_data, crc_final;
  logic              in_fire, out_free, rd_en;

  // payload memory and sequence memory
  byte_t             pay_mem [PAYLOAD_BYTES];
  byte_t             pay_rdata_r;
  seq_t              seq_mem [NUM_CAMS];
  logic [NUM_CAMS-1:0] seq_vld_r;
  seq_t              seq_exp_r;
  seq_t              seq_next_tab [1 << SEQ_W];

  assign in_ready = (state_r != ST_DRAIN);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign rd_en    = (state_r == ST_DRAIN) && !rd_pend_r && out_free;

  crc8pd_crc_byte u_crc_data (
    .crc_in  (crc_acc_r),
    .data_in (in_rx_byte),
    .poly    (poly_r),
    .crc_out (crc_data)
  );

  crc8pd_crc_byte u_crc_final (
    .crc_in  (crc_acc_r),
    .data_in (addr_r),
    .poly    (poly_r),
    .crc_out (crc_final)
  );

  for (genvar g = 0; g < (1 << SEQ_W); g++) begin : g_seq_tab
    localparam int unsigned NV = (g + 1) % SEQ_MODULUS;
    assign seq_next_tab[g] = SEQ_W'(NV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r <= '0;
      poly_r     <= 8'h07;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PREAMBLE: preamble_r <= cfg_wdata;
        CFG_POLY:     poly_r     <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HUNT: begin
        if (in_fire && in_rx_byte == preamble_r) state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        if (in_fire) state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (in_fire && wr_idx_r == LAST_IDX) state_nxt = ST_CRC;
      end
      ST_CRC: begin
        if (in_fire) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (rd_pend_r && rd_idx_r == LAST_IDX) state_nxt = ST_HUNT;
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      addr_r      <= '0;
      crc_acc_r   <= '0;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      seq_vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        case (state_r)
          ST_ADDR: begin
            addr_r    <= addr_t'(in_rx_byte);
            crc_acc_r <= '0;
            wr_idx_r  <= '0;
          end
          ST_DATA: begin
            crc_acc_r <= crc_data;
            wr_idx_r  <= wr_idx_r + 1'b1;
          end
          ST_CRC: begin
            crc_acc_r <= crc_final;
            wr_idx_r  <= '0;
            rd_idx_r  <= '0;
            seq_vld_r[addr_r.cam] <= 1'b1;
          end
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      rd_pend_r <= rd_en;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
        rd_idx_r    <= rd_idx_r + 1'b1;
      end
    end
  end

  // packet flags and output data registers
  always_ff @(posedge clk) begin
    if (in_fire && state_r == ST_CRC) begin
      crc_err_r <= (crc_final != in_rx_byte);
      lost_r    <= (addr_r.seq != seq_exp_r);
    end
    if (rd_pend_r) begin
      out_data_r    <= pay_rdata_r;
      out_last_r    <= (rd_idx_r == LAST_IDX);
      out_cam_r     <= addr_r.cam;
      out_port_r    <= addr_r.port;
      out_crc_err_r <= crc_err_r;
      out_lost_r    <= lost_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && state_r == ST_DATA) pay_mem[wr_idx_r] <= in_rx_byte;
    if (rd_en) pay_rdata_r <= pay_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (in_fire && state_r == ST_CRC) seq_mem[addr_r.cam] <= seq_next_tab[addr_r.seq];
    seq_exp_r <= seq_vld_r[addr_r.cam] ? seq_mem[addr_r.cam] : '0;
  end

  assign out_valid        = out_valid_r;
  assign out_camera_id    = out_cam_r;
  assign out_port_id      = out_port_r;
  assign out_payload_byte = out_data_r;
  assign out_last_byte    = out_last_r;
  assign out_crc_error    = out_crc_err_r;
  assign out_packet_lost  = out_lost_r;

  a_crc_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && state_r == ST_CRC) |=> (state_r == ST_DRAIN))
    else $error("crc byte did not start the drain");

  a_out_free_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("payload read returned while output register full");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_pend_r && rd_idx_r == LAST_IDX) |=> (state_r == ST_HUNT))
    else $error("drain still running after last payload byte");

  a_drain_reads_only: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !in_fire)
    else $error("input request taken during payload drain");

endmodule
